@@ rtl/tsd_pkg.sv @@
package tsd_pkg;

    localparam logic [7:0] DIR_MASK = 8'h80;
    localparam logic [7:0] LEN_MASK = 8'h7f;

    // Position within a transaction; codes above PH_DATA never arise and decode as header.
    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_ADDR_HI  = 3'd1,
        PH_ADDR_MID = 3'd2,
        PH_ADDR_LO  = 3'd3,
        PH_DATA     = 3'd4
    } phase_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] mosi;
        logic [7:0] miso;
    } item_t;

    typedef struct packed {
        phase_t      phase;
        logic        duplex_warning;
        logic        data_valid;
        logic [7:0]  lane_byte;
        logic [6:0]  data_index;
        logic        transaction_done;
        logic        is_read;
        logic [7:0]  transfer_length;
        logic [23:0] address;
        logic        wait_flag;
    } res_t;

endpackage

@@ rtl/tsd_core.sv @@
module tsd_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic [7:0]     mosi,
    input  logic [7:0]     miso,
    output tsd_pkg::res_t  res
);
    import tsd_pkg::*;

    phase_t      cur_phase_reg, cur_phase_next;
    logic        dir_read_reg, dir_read_next;
    logic [7:0]  len_total_reg, len_total_next;
    logic [23:0] addr_reg, addr_next;
    logic        wait_seen_reg, wait_seen_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  count_inc;
    logic [7:0]  cross_lane;
    logic        last_byte;

    assign count_inc  = byte_count_reg + 8'd1;
    assign cross_lane = dir_read_reg ? mosi : miso;
    assign last_byte  = (count_inc >= len_total_reg);

    always_comb
    begin
        cur_phase_next  = cur_phase_reg;
        dir_read_next   = dir_read_reg;
        len_total_next  = len_total_reg;
        addr_next       = addr_reg;
        wait_seen_next  = wait_seen_reg;
        byte_count_next = byte_count_reg;
        case (cur_phase_reg)
            PH_ADDR_HI, PH_ADDR_MID:
            begin
                addr_next      = {addr_reg[15:0], mosi};
                cur_phase_next = (cur_phase_reg == PH_ADDR_HI) ? PH_ADDR_MID : PH_ADDR_LO;
            end
            PH_ADDR_LO:
            begin
                addr_next      = {addr_reg[15:0], mosi};
                wait_seen_next = (miso == 8'd0);
                cur_phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                byte_count_next = count_inc;
                if (last_byte)
                begin
                    cur_phase_next  = PH_HEADER;
                    byte_count_next = 8'd0;
                end
            end
            default:
            begin
                // Header byte: direction and length minus one.
                dir_read_next   = ((mosi & DIR_MASK) == DIR_MASK);
                len_total_next  = (mosi & LEN_MASK) + 8'd1;
                byte_count_next = 8'd0;
                wait_seen_next  = 1'b0;
                cur_phase_next  = PH_ADDR_HI;
            end
        endcase
    end

    always_comb
    begin
        res = '0;
        case (cur_phase_reg)
            PH_ADDR_HI, PH_ADDR_MID:
            begin
                res.phase          = cur_phase_reg;
                res.duplex_warning = (miso != 8'd0);
            end
            PH_ADDR_LO:
            begin
                res.phase          = PH_ADDR_LO;
                res.duplex_warning = (miso > 8'd1);
            end
            PH_DATA:
            begin
                res.phase          = PH_DATA;
                res.duplex_warning = (cross_lane != 8'd0);
                res.data_valid     = 1'b1;
                res.lane_byte      = dir_read_reg ? miso : mosi;
                res.data_index     = byte_count_reg[6:0];
                if (last_byte)
                begin
                    res.transaction_done = 1'b1;
                    res.is_read          = dir_read_reg;
                    res.transfer_length  = len_total_reg;
                    res.address          = addr_reg;
                    res.wait_flag        = wait_seen_reg;
                end
            end
            default:
            begin
                res.phase          = PH_HEADER;
                res.duplex_warning = (miso != 8'd0);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_phase_reg  <= PH_HEADER;
            dir_read_reg   <= 1'b0;
            len_total_reg  <= 8'd0;
            addr_reg       <= 24'd0;
            wait_seen_reg  <= 1'b0;
            byte_count_reg <= 8'd0;
        end
        else if (advance)
        begin
            cur_phase_reg  <= cur_phase_next;
            dir_read_reg   <= dir_read_next;
            len_total_reg  <= len_total_next;
            addr_reg       <= addr_next;
            wait_seen_reg  <= wait_seen_next;
            byte_count_reg <= byte_count_next;
        end
    end

endmodule

@@ rtl/tpm_spi_transaction_decoder.sv @@
// Decoder for TPM TIS transactions seen as SPI byte pairs.
//
// Input stream: one transfer per SPI byte pair. s_tdata carries MOSI and MISO,
// s_tuser marks events that are not byte pairs; those are dropped without a result.
// Output stream: one transfer per byte pair, describing the byte (header, address
// or data) with its phase, duplex warning and, for data bytes, the byte and index.
// m_tlast is high on the last data byte and that transfer also carries the
// direction, length, address and wait flag of the finished transaction.
//
// An item passes through an input register and then a result register, which
// drives m_tvalid. One item is taken every cycle while the output side keeps up.
// When the receiver stalls, the result register holds, the input register fills,
// and s_tready then drops until m_tready returns.
// Reset clears both valid bits and returns the decoder to the header phase.
module tpm_spi_transaction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mosi[7:0], miso[15:8]
    input  logic        s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // lane_byte[7:0], data_index[14:8], is_read[15],
                                   // transfer_length[23:16], address[47:24],
                                   // wait_flag[48], zero[55:49]
    output logic        m_tlast,   // transaction_done
    output logic [4:0]  m_tuser    // phase[2:0], duplex_warning[3], data_valid[4]
);
    import tsd_pkg::*;

    logic  in_valid_reg;
    item_t in_item_reg;
    logic  out_valid_reg;
    res_t  out_res_reg;
    logic  out_free;
    logic  in_advance;
    logic  decode_en;
    res_t  core_res;

    assign out_free   = !out_valid_reg || m_tready;
    // Events that are not byte pairs leave without waiting for the output side.
    assign in_advance = in_valid_reg && (in_item_reg.cmd || out_free);
    assign decode_en  = in_advance && !in_item_reg.cmd;
    assign s_tready   = !in_valid_reg || in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.cmd  <= s_tuser;
            in_item_reg.mosi <= s_tdata[7:0];
            in_item_reg.miso <= s_tdata[15:8];
        end
    end

    tsd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (decode_en),
        .mosi    (in_item_reg.mosi),
        .miso    (in_item_reg.miso),
        .res     (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= decode_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decode_en)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.transaction_done;
    assign m_tuser  = {out_res_reg.data_valid, out_res_reg.duplex_warning, out_res_reg.phase};
    assign m_tdata  = {7'd0, out_res_reg.wait_flag, out_res_reg.address,
                       out_res_reg.transfer_length, out_res_reg.is_read,
                       out_res_reg.data_index, out_res_reg.lane_byte};

    a_done_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[4] && (out_res_reg.phase == PH_DATA))
        else $error("transaction end flagged on a byte that is not data");

    a_no_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[4] |-> (m_tdata[14:0] == 15'd0) && !m_tlast)
        else $error("data fields set on a header or address byte");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("input register lost a stalled item");

    a_result_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
        out_free && !decode_en |=> !m_tvalid)
        else $error("result produced without a decoded byte pair");

endmodule

@@ tb/tpm_spi_transaction_decoder_check.sv @@
`timescale 1ns / 100ps

module tpm_spi_transaction_decoder_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // mosi[7:0], miso[15:8]
    input  logic        s_tuser,   // cmd[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // lane_byte[7:0], data_index[14:8], is_read[15],
                                   // transfer_length[23:16], address[47:24],
                                   // wait_flag[48], zero[55:49]
    input  logic        m_tlast,   // transaction_done
    input  logic [4:0]  m_tuser,   // phase[2:0], duplex_warning[3], data_valid[4]
    output int unsigned errors,
    output int unsigned outstanding,
    output int unsigned results_checked,
    output int unsigned transactions_done,
    output int unsigned waits_seen,
    output int unsigned warnings_seen,
    output logic        at_header
);
    import tsd_pkg::*;

    // Our own view of the decoder's framing state.
    phase_t      cur_ph;
    logic        rd_dir;
    logic [7:0]  xfer_len;
    logic [23:0] addr_acc;
    logic        wait_mark;
    logic [7:0]  byte_cnt;
    res_t        expected_results[$];

    assign at_header = (cur_ph == PH_HEADER);

    function automatic res_t decode_pair(input logic [7:0] mo, input logic [7:0] mi);
        res_t       r;
        logic [7:0] other_lane;
        r = '0;
        case (cur_ph)
            PH_ADDR_HI, PH_ADDR_MID:
            begin
                r.phase = cur_ph;
                r.duplex_warning = (mi != 8'h00);
                addr_acc = {addr_acc[15:0], mo};
                cur_ph = (cur_ph == PH_ADDR_HI) ? PH_ADDR_MID : PH_ADDR_LO;
            end
            PH_ADDR_LO:
            begin
                // The device answers 0 to request wait states and 1 when ready.
                r.phase = PH_ADDR_LO;
                addr_acc = {addr_acc[15:0], mo};
                wait_mark = (mi == 8'h00);
                r.duplex_warning = (mi > 8'h01);
                cur_ph = PH_DATA;
            end
            PH_DATA:
            begin
                r.phase = PH_DATA;
                other_lane = rd_dir ? mo : mi;
                r.lane_byte = rd_dir ? mi : mo;
                r.duplex_warning = (other_lane != 8'h00);
                r.data_valid = 1'b1;
                r.data_index = byte_cnt[6:0];
                byte_cnt = byte_cnt + 8'd1;
                if (byte_cnt >= xfer_len)
                begin
                    r.transaction_done = 1'b1;
                    r.is_read = rd_dir;
                    r.transfer_length = xfer_len;
                    r.address = addr_acc;
                    r.wait_flag = wait_mark;
                    cur_ph = PH_HEADER;
                    byte_cnt = 8'd0;
                end
            end
            default:
            begin
                r.phase = PH_HEADER;
                r.duplex_warning = (mi != 8'h00);
                rd_dir = ((mo & DIR_MASK) == DIR_MASK);
                xfer_len = (mo & LEN_MASK) + 8'd1;
                byte_cnt = 8'd0;
                wait_mark = 1'b0;
                cur_ph = PH_ADDR_HI;
            end
        endcase
        return r;
    endfunction

    function automatic string describe(input res_t r);
        return {$sformatf("phase=%0d warn=%0b dv=%0b byte=%h idx=%0d ",
                          r.phase, r.duplex_warning, r.data_valid, r.lane_byte,
                          r.data_index),
                $sformatf("done=%0b rd=%0b len=%0d addr=%h wait=%0b",
                          r.transaction_done, r.is_read, r.transfer_length,
                          r.address, r.wait_flag)};
    endfunction

    task automatic flag_error(input string msg);
        if (errors < 10)
            $display("%0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_ph = PH_HEADER;
            rd_dir = 1'b0;
            xfer_len = 8'd0;
            addr_acc = 24'd0;
            wait_mark = 1'b0;
            byte_cnt = 8'd0;
            expected_results.delete();
            errors = 0;
            outstanding = 0;
            results_checked = 0;
            transactions_done = 0;
            waits_seen = 0;
            warnings_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                res_t seen;
                res_t want;
                seen.phase = phase_t'(m_tuser[2:0]);
                seen.duplex_warning = m_tuser[3];
                seen.data_valid = m_tuser[4];
                seen.lane_byte = m_tdata[7:0];
                seen.data_index = m_tdata[14:8];
                seen.transaction_done = m_tlast;
                seen.is_read = m_tdata[15];
                seen.transfer_length = m_tdata[23:16];
                seen.address = m_tdata[47:24];
                seen.wait_flag = m_tdata[48];
                results_checked++;
                if (m_tlast === 1'b1)
                    transactions_done++;
                if (m_tlast === 1'b1 && m_tdata[48] === 1'b1)
                    waits_seen++;
                if (m_tuser[3] === 1'b1)
                    warnings_seen++;
                if (expected_results.size() == 0)
                    flag_error({"result with nothing expected: ", describe(seen)});
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.phase !== want.phase
                        || seen.duplex_warning !== want.duplex_warning
                        || seen.data_valid !== want.data_valid
                        || seen.lane_byte !== want.lane_byte
                        || seen.data_index !== want.data_index
                        || seen.transaction_done !== want.transaction_done
                        || seen.is_read !== want.is_read
                        || seen.transfer_length !== want.transfer_length
                        || seen.address !== want.address
                        || seen.wait_flag !== want.wait_flag
                        || m_tdata[55:49] !== 7'd0)
                        flag_error({"mismatch\n  expected ", describe(want),
                                    "\n  actual   ", describe(seen),
                                    $sformatf(" pad=%h", m_tdata[55:49])});
                end
            end
            // Other SPI events leave the framing untouched and produce nothing.
            if (s_tvalid && s_tready && !s_tuser)
                expected_results.push_back(decode_pair(s_tdata[7:0], s_tdata[15:8]));
            outstanding = expected_results.size();
        end
    end

endmodule

@@ tb/tpm_spi_transaction_decoder_test.sv @@
`timescale 1ns / 100ps

module tpm_spi_transaction_decoder_test;

    localparam int unsigned LONG_HOLD = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = 16'h0000;   // mosi[7:0], miso[15:8]
    logic        s_tuser = 1'b0;       // cmd[0]
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [55:0] m_tdata;              // lane_byte[7:0], data_index[14:8], is_read[15],
                                       // transfer_length[23:16], address[47:24],
                                       // wait_flag[48], zero[55:49]
    wire         m_tlast;              // transaction_done
    wire  [4:0]  m_tuser;              // phase[2:0], duplex_warning[3], data_valid[4]

    int unsigned errors;
    int unsigned outstanding;
    int unsigned results_checked;
    int unsigned transactions_done;
    int unsigned waits_seen;
    int unsigned warnings_seen;
    logic        at_header;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned pairs_sent = 0;
    int unsigned events_sent = 0;
    logic        long_hold_req = 1'b0;

    always #5 clk = ~clk;

    tpm_spi_transaction_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    tpm_spi_transaction_decoder_check decode_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .m_tuser           (m_tuser),
        .errors            (errors),
        .outstanding       (outstanding),
        .results_checked   (results_checked),
        .transactions_done (transactions_done),
        .waits_seen        (waits_seen),
        .warnings_seen     (warnings_seen),
        .at_header         (at_header)
    );

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Timeout with %0d results still outstanding.", outstanding);
        $display("FAIL");
        $finish;
    end

    // Offers one item and returns at the falling edge after its transfer.
    task automatic send_pair(input logic ev, input logic [7:0] mo, input logic [7:0] mi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev;
        s_tdata  <= {mi, mo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (ev)
            events_sent++;
        else
            pairs_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] lane_noise(input bit noisy);
        return (noisy && $urandom_range(3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    endfunction

    // A byte pair of a transaction, sometimes preceded by an unrelated SPI event.
    task automatic send_byte(input bit noisy, input logic [7:0] mo, input logic [7:0] mi);
        if (noisy && $urandom_range(7) == 0)
            send_pair(1'b1, 8'($urandom), 8'($urandom));
        send_pair(1'b0, mo, mi);
    endtask

    task automatic send_transaction(input bit noisy);
        bit          rd;
        int unsigned len;
        int unsigned pick;
        logic [23:0] adr;
        logic [7:0]  lo_miso;
        logic [7:0]  payload;
        rd = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 3)
            len = 128;
        else if (pick < 10)
            len = $urandom_range(9, 128);
        else
            len = $urandom_range(1, 8);
        if ($urandom_range(1))
            adr = {8'hD4, 4'h0, 12'($urandom)};
        else
            adr = 24'($urandom);
        if (noisy && $urandom_range(3) == 0)
            lo_miso = 8'($urandom);
        else
            lo_miso = 8'($urandom_range(1));
        send_byte(noisy, {rd, 7'(len - 1)}, lane_noise(noisy));
        send_byte(noisy, adr[23:16], lane_noise(noisy));
        send_byte(noisy, adr[15:8], lane_noise(noisy));
        send_byte(noisy, adr[7:0], lo_miso);
        repeat (len)
        begin
            payload = 8'($urandom);
            if (rd)
                send_byte(noisy, lane_noise(noisy), payload);
            else
                send_byte(noisy, payload, lane_noise(noisy));
        end
    endtask

    // Stray bytes break the framing; random filler runs until a header is due again.
    task automatic send_broken();
        repeat ($urandom_range(1, 3))
            send_pair(1'b0, 8'($urandom), 8'($urandom));
        while (!at_header)
            send_pair(1'b0, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned idle_mix[4];
        int unsigned stall_mix[4];
        int unsigned target;
        int unsigned pick;
        idle_mix = '{0, 76, 0, 27};
        stall_mix = '{0, 0, 76, 27};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Ignored event straight after reset.
        send_pair(1'b1, 8'hFF, 8'hFF);
        // Shortest write to the top address, device ready.
        send_pair(1'b0, 8'h00, 8'h00);
        send_pair(1'b0, 8'hFF, 8'h00);
        send_pair(1'b0, 8'hFF, 8'h00);
        send_pair(1'b0, 8'hFF, 8'h01);
        send_pair(1'b0, 8'hFF, 8'h00);
        // Two-byte read at address zero with a wait state and warnings on every kind of byte.
        send_pair(1'b0, 8'h81, 8'h80);
        send_pair(1'b0, 8'h00, 8'h01);
        send_pair(1'b0, 8'h00, 8'h00);
        send_pair(1'b1, 8'h5A, 8'hA5);
        send_pair(1'b0, 8'h00, 8'h00);
        send_pair(1'b0, 8'h00, 8'h00);
        send_pair(1'b0, 8'h7F, 8'hFF);
        // Write with illegal MISO on the last address byte and a busy MISO lane on data.
        send_pair(1'b0, 8'h00, 8'h00);
        send_pair(1'b0, 8'hD4, 8'h00);
        send_pair(1'b0, 8'h0F, 8'h00);
        send_pair(1'b0, 8'h00, 8'h02);
        send_pair(1'b0, 8'h01, 8'hFE);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            target = pairs_sent + 480;
            while (pairs_sent < target)
            begin
                pick = $urandom_range(199);
                if (pick < 3)
                    send_broken();
                else if (pick < 20)
                    send_pair(1'b1, 8'($urandom), 8'($urandom));
                else
                    send_transaction($urandom_range(3) == 0);
            end

            if (p == 0)
            begin
                // Let everything drain, then stall the output while items keep coming.
                wait_drained();
                @(posedge clk);
                long_hold_req = 1'b1;
                @(negedge clk);
                target = pairs_sent + 40;
                while (pairs_sent < target)
                    send_transaction(1'b0);
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);

        $display("Sent %0d byte pairs and %0d other events; four idle/stall mixes, one long stall.",
                 pairs_sent, events_sent);
        $display("Checked %0d results, %0d transactions (%0d with wait), %0d warnings.",
                 results_checked, transactions_done, waits_seen, warnings_seen);
        if (errors == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
